@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the RTL files of this block.
// Each macro expands to one labeled concurrent assertion with a reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/icdw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C command/data writer package
// Shared item type and protocol constants for the write sequencer.
// ----------------------------------------------------------------------------
package icdw_pkg;

   localparam logic [7:0] ADDR_RESET  = 8'h78;
   localparam logic [7:0] CTRL_DATA   = 8'h40;
   localparam logic [7:0] CTRL_CMD    = 8'h00;
   localparam logic [7:0] MSB_MASK    = 8'h80;
   localparam int         QUEUE_DEPTH = 2;

   // One tick of input as it travels from the front queue to the sequencer.
   typedef struct packed {
      logic       start_request;
      logic       operation;
      logic [7:0] payload;
      logic       sda_sample;
   } item_type;

endpackage

@@ rtl/core/icdw_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one tick of requests and line samples.
// ----------------------------------------------------------------------------
interface icdw_req_if;
   logic       valid;
   logic       ready;
   logic       start_request;
   logic       operation;
   logic [7:0] payload;
   logic       sda_sample;

   modport source (output valid, output start_request, output operation,
                   output payload, output sda_sample, input ready);
   modport sink   (input valid, input start_request, input operation,
                   input payload, input sda_sample, output ready);
endinterface

@@ rtl/core/icdw_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries the bus levels and status of one tick.
// ----------------------------------------------------------------------------
interface icdw_rsp_if;
   logic valid;
   logic ready;
   logic scl_level;
   logic sda_level;
   logic sda_drive;
   logic busy_res;
   logic done_res;
   logic address_nack;

   modport source (output valid, output scl_level, output sda_level,
                   output sda_drive, output busy_res, output done_res,
                   output address_nack, input ready);
   modport sink   (input valid, input scl_level, input sda_level,
                   input sda_drive, input busy_res, input done_res,
                   input address_nack, output ready);
endinterface

@@ rtl/core/icdw_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request front end
// Accepts request transactions and holds them in a short queue for the
// sequencer, so the request side never waits on a stalled response side
// until the queue is full.
// ----------------------------------------------------------------------------
module icdw_front #(
   parameter int Depth = icdw_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   icdw_req_if.sink           req_chan,
   input  logic               item_pop,
   output logic               item_valid,
   output icdw_pkg::item_type item
);
   import icdw_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   item_type          queue_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff;
   logic [PtrW-1:0]   wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff;
   logic [PtrW-1:0]   rd_ptr_in;
   logic [CntW-1:0]   count_ff;
   logic [CntW-1:0]   count_in;
   logic              push;
   item_type          push_item;

   assign req_chan.ready = (count_ff != CntW'(Depth));
   assign push           = req_chan.valid && req_chan.ready;
   assign item_valid     = (count_ff != '0);
   assign item           = queue_ff[rd_ptr_ff];

   always_comb begin
      push_item.start_request = req_chan.start_request;
      push_item.operation     = req_chan.operation;
      push_item.payload       = req_chan.payload;
      push_item.sda_sample    = req_chan.sda_sample;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (item_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !item_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && item_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/core/icdw_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bus phase sequencer
// Steps the I2C write sequence by one pin phase per queued tick and
// registers the resulting line levels and status as a response transaction.
// ----------------------------------------------------------------------------
module icdw_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  icdw_pkg::item_type item,
   output logic               item_pop,
   input  logic               csr_wr_en,
   input  logic [7:0]         csr_wr_data,
   icdw_rsp_if.source         rsp_chan
);
   import icdw_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_START_SCL,
      PH_BIT_SET,
      PH_BIT_SCLH,
      PH_BIT_SCLL,
      PH_BIT_SDAL,
      PH_ACK_REL,
      PH_ACK_SCLH,
      PH_ACK_SAMP,
      PH_ACK_SCLL,
      PH_ACK_DRV,
      PH_STOP_SCL,
      PH_STOP_SDA
   } phase_type;

   logic [7:0] dev_addr_ff;
   phase_type  phase_ff,   phase_in;
   logic [2:0] bit_idx_ff, bit_idx_in;
   logic [1:0] byte_idx_ff, byte_idx_in;
   logic       op_ff,      op_in;
   logic [7:0] payload_ff, payload_in;
   logic       scl_ff,     scl_in;
   logic       sda_ff,     sda_in;
   logic       sda_en_ff,  sda_en_in;
   logic       nack_ff,    nack_in;
   logic       done_in;
   logic [7:0] cur_byte;

   logic rsp_valid_ff;
   logic rsp_scl_ff;
   logic rsp_sda_ff;
   logic rsp_drive_ff;
   logic rsp_busy_ff;
   logic rsp_done_ff;
   logic rsp_nack_ff;

   // One tick is consumed whenever the response register is free or draining.
   assign item_pop = item_valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      unique case (byte_idx_ff)
         2'd0:    cur_byte = dev_addr_ff;
         2'd1:    cur_byte = op_ff ? CTRL_DATA : CTRL_CMD;
         default: cur_byte = payload_ff;
      endcase
   end

   always_comb begin
      phase_in    = phase_ff;
      bit_idx_in  = bit_idx_ff;
      byte_idx_in = byte_idx_ff;
      op_in       = op_ff;
      payload_in  = payload_ff;
      scl_in      = scl_ff;
      sda_in      = sda_ff;
      sda_en_in   = sda_en_ff;
      nack_in     = nack_ff;
      done_in     = 1'b0;

      unique case (phase_ff)
         PH_START_SCL: begin
            scl_in      = 1'b0;
            bit_idx_in  = '0;
            byte_idx_in = '0;
            phase_in    = PH_BIT_SET;
         end
         PH_BIT_SET: begin
            sda_in   = |(cur_byte & (MSB_MASK >> bit_idx_ff));
            phase_in = PH_BIT_SCLH;
         end
         PH_BIT_SCLH: begin
            scl_in   = 1'b1;
            phase_in = PH_BIT_SCLL;
         end
         PH_BIT_SCLL: begin
            scl_in   = 1'b0;
            phase_in = PH_BIT_SDAL;
         end
         PH_BIT_SDAL: begin
            sda_in = 1'b0;
            if (bit_idx_ff == 3'd7) begin
               phase_in = PH_ACK_REL;
            end else begin
               bit_idx_in = bit_idx_ff + 1'b1;
               phase_in   = PH_BIT_SET;
            end
         end
         PH_ACK_REL: begin
            sda_en_in = 1'b0;
            phase_in  = PH_ACK_SCLH;
         end
         PH_ACK_SCLH: begin
            scl_in   = 1'b1;
            phase_in = PH_ACK_SAMP;
         end
         PH_ACK_SAMP: begin
            // Only the address byte's acknowledge is checked.
            if (byte_idx_ff == 2'd0 && item.sda_sample) begin
               nack_in = 1'b1;
            end
            phase_in = PH_ACK_SCLL;
         end
         PH_ACK_SCLL: begin
            scl_in   = 1'b0;
            phase_in = PH_ACK_DRV;
         end
         PH_ACK_DRV: begin
            sda_en_in = 1'b1;
            if (nack_ff || byte_idx_ff[1]) begin
               phase_in = PH_STOP_SCL;
            end else begin
               byte_idx_in = byte_idx_ff + 1'b1;
               bit_idx_in  = '0;
               phase_in    = PH_BIT_SET;
            end
         end
         PH_STOP_SCL: begin
            scl_in   = 1'b1;
            phase_in = PH_STOP_SDA;
         end
         PH_STOP_SDA: begin
            sda_in      = 1'b1;
            done_in     = 1'b1;
            bit_idx_in  = '0;
            byte_idx_in = '0;
            phase_in    = PH_IDLE;
         end
         default: begin
            phase_in  = PH_IDLE;
            scl_in    = 1'b1;
            sda_in    = 1'b1;
            sda_en_in = 1'b1;
            if (item.start_request) begin
               op_in       = item.operation;
               payload_in  = item.payload;
               nack_in     = 1'b0;
               bit_idx_in  = '0;
               byte_idx_in = '0;
               sda_in      = 1'b0;
               phase_in    = PH_START_SCL;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff  <= ADDR_RESET;
         phase_ff     <= PH_IDLE;
         bit_idx_ff   <= '0;
         byte_idx_ff  <= '0;
         op_ff        <= 1'b0;
         payload_ff   <= '0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         sda_en_ff    <= 1'b1;
         nack_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_scl_ff   <= 1'b1;
         rsp_sda_ff   <= 1'b1;
         rsp_drive_ff <= 1'b1;
         rsp_busy_ff  <= 1'b0;
         rsp_done_ff  <= 1'b0;
         rsp_nack_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            dev_addr_ff <= csr_wr_data;
         end
         if (item_pop) begin
            phase_ff     <= phase_in;
            bit_idx_ff   <= bit_idx_in;
            byte_idx_ff  <= byte_idx_in;
            op_ff        <= op_in;
            payload_ff   <= payload_in;
            scl_ff       <= scl_in;
            sda_ff       <= sda_in;
            sda_en_ff    <= sda_en_in;
            nack_ff      <= nack_in;
            rsp_valid_ff <= 1'b1;
            rsp_scl_ff   <= scl_in;
            // A released line rests high through the pull-up.
            rsp_sda_ff   <= sda_en_in ? sda_in : 1'b1;
            rsp_drive_ff <= sda_en_in;
            rsp_busy_ff  <= (phase_in != PH_IDLE);
            rsp_done_ff  <= done_in;
            rsp_nack_ff  <= done_in && nack_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.scl_level    = rsp_scl_ff;
   assign rsp_chan.sda_level    = rsp_sda_ff;
   assign rsp_chan.sda_drive    = rsp_drive_ff;
   assign rsp_chan.busy_res     = rsp_busy_ff;
   assign rsp_chan.done_res     = rsp_done_ff;
   assign rsp_chan.address_nack = rsp_nack_ff;

endmodule

@@ rtl/core/i2c_master_command_data_writer.sv @@
`timescale 1ns / 1ps
// Each request transaction is one tick of the bus sequencer and yields exactly one
// response transaction with the SCL/SDA levels and status after that tick. The block
// takes one tick per clock cycle while the queue has room; a tick enters a two-entry
// queue and leaves it into the phase sequencer, whose response register holds the
// result, so a tick's response is offered only after the tick has passed through
// the queue and into the response register. A full byte costs 32 ticks plus 5
// for its acknowledge; a complete write takes 1 + 1 + 3 * 37 + 2 ticks.
// The address register may be written only while no ticks are outstanding.
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// I2C command/data writer
// Bit-level I2C master that writes an address, a control byte and one
// command or data byte, one pin phase per request transaction.
// ----------------------------------------------------------------------------
module i2c_master_command_data_writer #(
   parameter int QueueDepth = icdw_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   icdw_req_if.sink   req_chan,
   icdw_rsp_if.source rsp_chan,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);
   import icdw_pkg::*;

   logic     item_valid;
   logic     item_pop;
   item_type item;
   logic     rsp_vld;
   logic     rsp_done;
   logic     rsp_busy;
   logic     rsp_nack;
   logic     rsp_drive;
   logic     rsp_sda;

   icdw_front #(
      .Depth (QueueDepth)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .item_pop   (item_pop),
      .item_valid (item_valid),
      .item       (item)
   );

   icdw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item        (item),
      .item_pop    (item_pop),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_chan    (rsp_chan)
   );

   assign rsp_vld   = rsp_chan.valid;
   assign rsp_done  = rsp_chan.done_res;
   assign rsp_busy  = rsp_chan.busy_res;
   assign rsp_nack  = rsp_chan.address_nack;
   assign rsp_drive = rsp_chan.sda_drive;
   assign rsp_sda   = rsp_chan.sda_level;

   `ASSERT_SAME(a_pop_needs_item, clock, reset, item_pop, item_valid, "pop from empty queue")
   `ASSERT_NEXT(a_pop_fills_rsp, clock, reset, item_pop, rsp_vld, "tick lost after pop")
   `ASSERT_SAME(a_done_not_busy, clock, reset, rsp_vld && rsp_done, !rsp_busy, "done while busy")
   `ASSERT_SAME(a_nack_done, clock, reset, rsp_vld && rsp_nack, rsp_done, "nack without done")
   `ASSERT_SAME(a_release_high, clock, reset, rsp_vld && !rsp_drive, rsp_sda, "SDA released low")

endmodule

@@ tb/sv/i2c_master_command_data_writer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C command/data writer testbench
// Sends whole write transfers, one bus tick per request transaction, and
// checks every response tick against a tick-exact model of the sequencer.
// Covers command and data writes, address not-acknowledged, requests while
// busy and on the stop tick, several address settings and mixes of input
// gaps and response stalls, including a long response hold-off.
// ----------------------------------------------------------------------------
module i2c_master_command_data_writer_tb;
   import icdw_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int HoldCycles = 300;

   typedef enum logic [4:0] {
      SEQ_IDLE, SEQ_START_SCL, SEQ_BIT_SET, SEQ_BIT_SCLH, SEQ_BIT_SCLL,
      SEQ_BIT_SDAL, SEQ_ACK_REL, SEQ_ACK_SCLH, SEQ_ACK_SAMP, SEQ_ACK_SCLL,
      SEQ_ACK_DRV, SEQ_STOP_SCL, SEQ_STOP_SDA
   } seq_phase_type;

   typedef struct packed {
      logic scl;
      logic sda;
      logic sda_drive;
      logic busy;
      logic done;
      logic nack;
   } bus_levels_type;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   icdw_req_if req_if ();
   icdw_rsp_if rsp_if ();

   i2c_master_command_data_writer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Model state of the bus sequencer.
   seq_phase_type seq_phase;
   logic [2:0] bit_sel;
   logic [1:0] byte_sel;
   logic       op_q;
   logic [7:0] payload_q;
   logic       scl_q;
   logic       sda_q;
   logic       sda_en_q;
   logic       nack_q;
   logic [7:0] addr_byte;

   bus_levels_type expected_levels[$];

   int send_idle_pct;
   int recv_stall_pct;
   int hold_requests;
   int holds_served;
   int hold_left;
   int ticks_sent;
   int ticks_checked;
   int transfers_seen;
   int nacks_seen;
   int mismatches;
   int cycle_count;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Timeout after %0d cycles with %0d responses outstanding.",
                  cycle_count, expected_levels.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Response side: random stalls, plus a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served = hold_requests;
         hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Advances the model by one tick and returns the levels it drives afterwards.
   function automatic bus_levels_type step_sequencer(input item_type t);
      bus_levels_type lv;
      logic       done;
      logic [7:0] cur;
      done = 1'b0;
      if (byte_sel == 2'd0) cur = addr_byte;
      else if (byte_sel == 2'd1) cur = op_q ? CTRL_DATA : CTRL_CMD;
      else cur = payload_q;
      case (seq_phase)
         SEQ_START_SCL: begin
            scl_q = 1'b0;
            bit_sel = 3'd0;
            byte_sel = 2'd0;
            seq_phase = SEQ_BIT_SET;
         end
         SEQ_BIT_SET: begin
            sda_q = |(cur & (MSB_MASK >> bit_sel));
            seq_phase = SEQ_BIT_SCLH;
         end
         SEQ_BIT_SCLH: begin
            scl_q = 1'b1;
            seq_phase = SEQ_BIT_SCLL;
         end
         SEQ_BIT_SCLL: begin
            scl_q = 1'b0;
            seq_phase = SEQ_BIT_SDAL;
         end
         SEQ_BIT_SDAL: begin
            sda_q = 1'b0;
            if (bit_sel == 3'd7) begin
               seq_phase = SEQ_ACK_REL;
            end else begin
               bit_sel = bit_sel + 3'd1;
               seq_phase = SEQ_BIT_SET;
            end
         end
         SEQ_ACK_REL: begin
            sda_en_q = 1'b0;
            seq_phase = SEQ_ACK_SCLH;
         end
         SEQ_ACK_SCLH: begin
            scl_q = 1'b1;
            seq_phase = SEQ_ACK_SAMP;
         end
         SEQ_ACK_SAMP: begin
            // Only the acknowledge of the address byte is looked at.
            if (byte_sel == 2'd0 && t.sda_sample) nack_q = 1'b1;
            seq_phase = SEQ_ACK_SCLL;
         end
         SEQ_ACK_SCLL: begin
            scl_q = 1'b0;
            seq_phase = SEQ_ACK_DRV;
         end
         SEQ_ACK_DRV: begin
            sda_en_q = 1'b1;
            if (nack_q || byte_sel >= 2'd2) begin
               seq_phase = SEQ_STOP_SCL;
            end else begin
               byte_sel = byte_sel + 2'd1;
               bit_sel = 3'd0;
               seq_phase = SEQ_BIT_SET;
            end
         end
         SEQ_STOP_SCL: begin
            scl_q = 1'b1;
            seq_phase = SEQ_STOP_SDA;
         end
         SEQ_STOP_SDA: begin
            sda_q = 1'b1;
            done = 1'b1;
            bit_sel = 3'd0;
            byte_sel = 2'd0;
            seq_phase = SEQ_IDLE;
         end
         default: begin
            seq_phase = SEQ_IDLE;
            scl_q = 1'b1;
            sda_q = 1'b1;
            sda_en_q = 1'b1;
            if (t.start_request) begin
               op_q = t.operation;
               payload_q = t.payload;
               nack_q = 1'b0;
               bit_sel = 3'd0;
               byte_sel = 2'd0;
               sda_q = 1'b0;
               seq_phase = SEQ_START_SCL;
            end
         end
      endcase
      lv.scl = scl_q;
      lv.sda = sda_en_q ? sda_q : 1'b1;
      lv.sda_drive = sda_en_q;
      lv.busy = (seq_phase != SEQ_IDLE);
      lv.done = done;
      lv.nack = done ? nack_q : 1'b0;
      return lv;
   endfunction

   function automatic void check_bit(input string what, input logic want, input logic got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %b, actual %b", $time, what, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : check_responses
      bus_levels_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_levels.size() == 0) begin
            $display("%0t ns: response mismatch, expected none, actual one transaction",
                     $time);
            mismatches++;
         end else begin
            want = expected_levels.pop_front();
            check_bit("scl_level", want.scl, rsp_if.scl_level);
            check_bit("sda_level", want.sda, rsp_if.sda_level);
            check_bit("sda_drive", want.sda_drive, rsp_if.sda_drive);
            check_bit("busy_res", want.busy, rsp_if.busy_res);
            check_bit("done_res", want.done, rsp_if.done_res);
            check_bit("address_nack", want.nack, rsp_if.address_nack);
            ticks_checked++;
            if (want.done) transfers_seen++;
            if (want.done && want.nack) nacks_seen++;
         end
      end
   end

   // Offers one tick, with an optional gap first, and records its expected response.
   task automatic send_tick(input item_type t);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.start_request <= t.start_request;
      req_if.operation <= t.operation;
      req_if.payload <= t.payload;
      req_if.sda_sample <= t.sda_sample;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      expected_levels.push_back(step_sequencer(t));
      ticks_sent++;
   endtask

   task automatic drain_responses();
      req_if.valid <= 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_address(input logic [7:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      addr_byte = value;
   endtask

   // One complete write: idle lead-in, the request, then ticks until the
   // model is idle again. The address acknowledge follows addr_nack; the other
   // samples are random. A pause_at above zero drains the responses after
   // that many ticks into the transfer.
   task automatic run_transfer(input logic op, input logic [7:0] pay, input bit addr_nack,
                               input int busy_req_pct, input bit req_on_done,
                               input int lead_idle, input int pause_at);
      item_type t;
      int n;
      repeat (lead_idle) begin
         t.start_request = 1'b0;
         t.operation = 1'($urandom);
         t.payload = 8'($urandom);
         t.sda_sample = 1'($urandom);
         send_tick(t);
      end
      t.start_request = 1'b1;
      t.operation = op;
      t.payload = pay;
      t.sda_sample = 1'($urandom);
      send_tick(t);
      n = 0;
      while (seq_phase != SEQ_IDLE) begin
         t.operation = 1'($urandom);
         t.payload = 8'($urandom);
         t.sda_sample = 1'($urandom);
         if (seq_phase == SEQ_STOP_SDA) t.start_request = req_on_done;
         else t.start_request = ($urandom_range(99) < busy_req_pct);
         if (seq_phase == SEQ_ACK_SAMP && byte_sel == 2'd0) t.sda_sample = addr_nack;
         send_tick(t);
         n++;
         if (n == pause_at) drain_responses();
      end
   endtask

   task automatic test_idle_ticks();
      item_type t;
      t.start_request = 1'b0;
      for (int i = 0; i < 8; i++) begin
         t.operation = i[0];
         t.payload = i[1] ? 8'hFF : 8'h00;
         t.sda_sample = i[2];
         send_tick(t);
      end
   endtask

   // Runs on the reset value of the address register with no idling.
   task automatic test_command_write();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      run_transfer(1'b0, 8'h00, 1'b0, 0, 1'b0, 0, -1);
   endtask

   // The sender idles most of the time.
   task automatic test_data_write();
      drain_responses();
      write_address(8'hFF);
      send_idle_pct = 79;
      recv_stall_pct = 0;
      run_transfer(1'b1, 8'hFF, 1'b0, 30, 1'b1, 1, -1);
   endtask

   // The receiver stalls most of the time.
   task automatic test_address_nack();
      drain_responses();
      write_address(8'h00);
      send_idle_pct = 0;
      recv_stall_pct = 79;
      run_transfer(1'b1, 8'hA5, 1'b1, 30, 1'b1, 2, -1);
      run_transfer(1'b0, 8'h5A, 1'b0, 0, 1'b0, 0, -1);
   endtask

   // The response side holds off while a transfer is offered, so the block
   // fills and stalls its input; later the sender stops mid-transfer until
   // every response is in. Both transfers have the address refused.
   task automatic test_backpressure();
      drain_responses();
      write_address(8'h78);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_requests++;
      run_transfer(1'b1, 8'($urandom), 1'b1, 5, 1'b0, 1, -1);
      run_transfer(1'b0, 8'($urandom), 1'b1, 5, 1'b0, 0, 20);
   endtask

   // Both sides idle now and then while one more transfer runs on a random address.
   task automatic test_random_traffic();
      drain_responses();
      write_address(8'($urandom));
      send_idle_pct = 20;
      recv_stall_pct = 20;
      run_transfer(1'($urandom), 8'($urandom), ($urandom_range(3) == 0), 10,
                   1'($urandom_range(1)), $urandom_range(3), -1);
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 8'h00;
      req_if.valid = 1'b0;
      req_if.start_request = 1'b0;
      req_if.operation = 1'b0;
      req_if.payload = 8'h00;
      req_if.sda_sample = 1'b0;
      rsp_if.ready = 1'b0;
      seq_phase = SEQ_IDLE;
      bit_sel = 3'd0;
      byte_sel = 2'd0;
      op_q = 1'b0;
      payload_q = 8'h00;
      scl_q = 1'b1;
      sda_q = 1'b1;
      sda_en_q = 1'b1;
      nack_q = 1'b0;
      addr_byte = ADDR_RESET;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_requests = 0;
      holds_served = 0;
      hold_left = 0;
      ticks_sent = 0;
      ticks_checked = 0;
      transfers_seen = 0;
      nacks_seen = 0;
      mismatches = 0;
      cycle_count = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_ticks();
      test_command_write();
      test_data_write();
      test_address_nack();
      test_backpressure();
      test_random_traffic();
      drain_responses();
      repeat (10) @(posedge clock);

      $display("Checked %0d ticks covering %0d write transfers, %0d with the address",
               ticks_checked, transfers_seen, nacks_seen);
      $display("not acknowledged, over several address settings and stall mixes.");
      if (mismatches == 0 && expected_levels.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/icdw_pkg.sv
rtl/core/icdw_req_if.sv
rtl/core/icdw_rsp_if.sv
rtl/core/icdw_front.sv
rtl/core/icdw_back.sv
rtl/core/i2c_master_command_data_writer.sv
tb/sv/i2c_master_command_data_writer_tb.sv
